// ===== hw/rtl/dwsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dwsc_pkg;

  // Table sizing
  localparam int MAX_PARTITIONS = 4;
  localparam int MAX_GROUPS     = 64;

  localparam int PIDX_W   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int GIDX_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int PCNT_W   = $clog2(MAX_PARTITIONS + 1);
  localparam int GCNT_W   = $clog2(MAX_GROUPS + 1);
  localparam int RAM_AW   = PIDX_W + GIDX_W;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  // Fixed field widths
  localparam int SEC_W     = 32;
  localparam int CFG_W     = 32;
  localparam int PIU_W     = 3;
  localparam int DS_W      = 33;  // first LBA plus one block
  localparam int SPG_W     = 39;  // blocks per group times up to 128 sectors
  localparam int ACC_W     = SPG_W + GCNT_W + 1;

  localparam logic [2:0] LOG_BS_MAX = 3'd6;
  localparam logic [SEC_W:0] SUPER_OFFSET = 33'd2;

  typedef enum logic [1:0] {
    REQ_CLASSIFY   = 2'd0,
    REQ_LOAD_PART  = 2'd1,
    REQ_LOAD_GROUP = 2'd2
  } req_e;

  typedef enum logic {
    CFG_MBR_SECTOR   = 1'b0,
    CFG_PARTS_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CLS_UNKNOWN = 4'd0,
    CLS_MBR     = 4'd1,
    CLS_SUPER   = 4'd2,
    CLS_DESC    = 4'd3,
    CLS_BMAP    = 4'd4,
    CLS_IMAP    = 4'd5,
    CLS_ITAB    = 4'd6,
    CLS_DATA    = 4'd7,
    CLS_PART    = 4'd8
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MBR  = 3'd1,
    ST_PART = 3'd2,
    ST_GRP  = 3'd3,
    ST_DONE = 3'd4
  } state_e;

  typedef struct packed {
    logic [SEC_W-1:0] itab_hi;
    logic [SEC_W-1:0] itab_lo;
    logic [SEC_W-1:0] imap_hi;
    logic [SEC_W-1:0] imap_lo;
    logic [SEC_W-1:0] bmap_hi;
    logic [SEC_W-1:0] bmap_lo;
    logic [SEC_W-1:0] desc;
  } grp_entry_t;

  typedef struct packed {
    logic accept;
    logic part_next;
    logic grp_init;
    logic grp_next;
    logic set_res;
    cls_e res;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_classify;
    logic mbr_hit;
    logic part_done;
    logic part_hit;
    logic super_hit;
    logic part_empty;
    logic grp_last;
    cls_e grp_cls;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dwsc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dwsc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwsc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dwsc_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [1:0]                    req_type_i,
  input  logic [1:0]                    part_index_i,
  input  logic [6:0]                    group_index_i,
  input  logic [dwsc_pkg::SEC_W-1:0]    sector_i,
  input  logic [dwsc_pkg::SEC_W-1:0]    value_a_i,
  input  logic [dwsc_pkg::SEC_W-1:0]    value_b_i,
  input  logic [dwsc_pkg::SEC_W-1:0]    value_c_i,
  input  logic [dwsc_pkg::SEC_W-1:0]    value_d_i,
  input  logic [dwsc_pkg::SEC_W-1:0]    value_e_i,
  input  logic [dwsc_pkg::SEC_W-1:0]    value_f_i,
  input  logic [2:0]                    log_block_size_i,
  input  logic                          first_data_block_i,
  input  logic                          out_ready_i,
  input  dwsc_pkg::ctrl_cmd_t           cmd_i,
  output dwsc_pkg::dp_sts_t             sts_o,
  output logic                          out_valid_o,
  output logic [3:0]                    sector_class_o
);
  import dwsc_pkg::*;

  // Configuration
  logic [SEC_W-1:0] mbr_q;
  logic [PIU_W-1:0] piu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbr_q <= '0;
      piu_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MBR_SECTOR:   mbr_q <= cfg_data_i[SEC_W-1:0];
        CFG_PARTS_IN_USE: piu_q <= cfg_data_i[PIU_W-1:0];
        default:          ;
      endcase
    end
  end

  // Partition table
  logic [SEC_W-1:0]  first_q [MAX_PARTITIONS];
  logic [SEC_W-1:0]  final_q [MAX_PARTITIONS];
  logic [DS_W-1:0]   ds_q    [MAX_PARTITIONS];
  logic [SPG_W-1:0]  spg_q   [MAX_PARTITIONS];
  logic [GCNT_W-1:0] gcnt_q  [MAX_PARTITIONS];

  logic              part_ok;
  logic              grp_ok;
  logic              load_part;
  logic              load_grp;
  logic [PIDX_W-1:0] ld_p;
  logic [2:0]        lg_sat;
  logic [7:0]        spb;
  logic [SPG_W-1:0]  spg_new;
  logic [DS_W-1:0]   ds_new;
  logic [GCNT_W-1:0] gcnt_new;

  assign part_ok   = int'(part_index_i) < MAX_PARTITIONS;
  assign grp_ok    = int'(group_index_i) < MAX_GROUPS;
  assign load_part = cmd_i.accept && (req_type_i == REQ_LOAD_PART) && part_ok;
  assign load_grp  = cmd_i.accept && (req_type_i == REQ_LOAD_GROUP) && part_ok && grp_ok;
  assign ld_p      = PIDX_W'(part_index_i);
  assign lg_sat    = (log_block_size_i > LOG_BS_MAX) ? LOG_BS_MAX : log_block_size_i;
  assign spb       = 8'd2 << lg_sat;
  assign spg_new   = SPG_W'(value_c_i) << ({1'b0, lg_sat} + 4'd1);
  assign ds_new    = first_data_block_i ? (DS_W'(value_a_i) + DS_W'(spb))
                                        : DS_W'(value_a_i);
  assign gcnt_new  = (int'(group_index_i) > MAX_GROUPS) ? GCNT_W'(MAX_GROUPS)
                                                        : GCNT_W'(group_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PARTITIONS; k++) begin
        gcnt_q[k] <= '0;
      end
    end else if (load_part) begin
      gcnt_q[ld_p] <= gcnt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_part) begin
      first_q[ld_p] <= value_a_i;
      final_q[ld_p] <= value_b_i;
      ds_q[ld_p]    <= ds_new;
      spg_q[ld_p]   <= spg_new;
    end
  end

  // Group table memory
  grp_entry_t        wr_entry;
  grp_entry_t        rd_entry;
  logic [RAM_AW-1:0] wr_addr;
  logic [RAM_AW-1:0] rd_addr;
  logic              rd_en;

  logic [SEC_W-1:0]  s_q;
  logic [PCNT_W-1:0] i_q;
  logic [GCNT_W-1:0] j_q;
  logic [GCNT_W-1:0] grp_cnt_q;
  logic [SPG_W-1:0]  grp_spg_q;
  logic [ACC_W-1:0]  acc_lo_q;
  logic [ACC_W-1:0]  acc_hi_q;
  logic [GCNT_W-1:0] j_next;
  logic [PIDX_W-1:0] pi;

  assign wr_entry = '{itab_hi: value_f_i, itab_lo: value_e_i,
                      imap_hi: value_d_i, imap_lo: value_c_i,
                      bmap_hi: value_b_i, bmap_lo: value_a_i,
                      desc: sector_i};
  assign wr_addr  = {ld_p, GIDX_W'(group_index_i)};
  assign pi       = i_q[PIDX_W-1:0];
  assign j_next   = j_q + GCNT_W'(1);
  assign rd_en    = cmd_i.grp_init || cmd_i.grp_next;
  assign rd_addr  = {pi, cmd_i.grp_init ? {GIDX_W{1'b0}} : j_next[GIDX_W-1:0]};

  dwsc_ram #(
    .WIDTH ($bits(grp_entry_t)),
    .DEPTH (RAM_DEPTH)
  ) u_grp_ram (
    .clk_i     (clk_i),
    .wr_en_i   (load_grp),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  // Scan state
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (req_type_i == REQ_CLASSIFY)) begin
      s_q <= sector_i;
      i_q <= '0;
    end else if (cmd_i.part_next) begin
      i_q <= i_q + PCNT_W'(1);
    end
    if (cmd_i.grp_init) begin
      j_q       <= '0;
      grp_cnt_q <= gcnt_q[pi];
      grp_spg_q <= spg_q[pi];
      acc_lo_q  <= ACC_W'(ds_q[pi]);
      acc_hi_q  <= ACC_W'(ds_q[pi]) + ACC_W'(spg_q[pi]);
    end else if (cmd_i.grp_next) begin
      j_q      <= j_next;
      acc_lo_q <= acc_hi_q;
      acc_hi_q <= acc_hi_q + ACC_W'(grp_spg_q);
    end
  end

  // Compares
  logic [PCNT_W-1:0] np;
  logic [ACC_W-1:0]  s_wide;
  cls_e              grp_cls;

  assign np     = (int'(piu_q) > MAX_PARTITIONS) ? PCNT_W'(MAX_PARTITIONS)
                                                 : PCNT_W'(piu_q);
  assign s_wide = ACC_W'(s_q);

  always_comb begin
    if (s_q == rd_entry.desc) begin
      grp_cls = CLS_DESC;
    end else if (s_q >= rd_entry.bmap_lo && s_q <= rd_entry.bmap_hi) begin
      grp_cls = CLS_BMAP;
    end else if (s_q >= rd_entry.imap_lo && s_q <= rd_entry.imap_hi) begin
      grp_cls = CLS_IMAP;
    end else if (s_q >= rd_entry.itab_lo && s_q <= rd_entry.itab_hi) begin
      grp_cls = CLS_ITAB;
    end else if (s_wide >= acc_lo_q && s_wide < acc_hi_q) begin
      grp_cls = CLS_DATA;
    end else begin
      grp_cls = CLS_UNKNOWN;
    end
  end

  // Result and output register
  cls_e res_q;
  cls_e class_q;
  logic out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res;
    end
    if (cmd_i.load_out) begin
      class_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sector_class_o = class_q;

  assign sts_o.is_classify = (req_type_i == REQ_CLASSIFY);
  assign sts_o.mbr_hit     = (s_q == mbr_q);
  assign sts_o.part_done   = (i_q >= np);
  assign sts_o.part_hit    = (s_q >= first_q[pi]) && (s_q <= final_q[pi]);
  assign sts_o.super_hit   = ({1'b0, s_q} == ({1'b0, first_q[pi]} + SUPER_OFFSET));
  assign sts_o.part_empty  = (gcnt_q[pi] == '0);
  assign sts_o.grp_last    = (j_next >= grp_cnt_q);
  assign sts_o.grp_cls     = grp_cls;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== hw/rtl/dwsc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dwsc_pkg::dp_sts_t   sts_i,
  output dwsc_pkg::ctrl_cmd_t cmd_o
);
  import dwsc_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res  = CLS_UNKNOWN;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.is_classify) begin
          state_d = ST_MBR;
        end
      end
      ST_MBR: begin
        if (sts_i.mbr_hit) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = CLS_MBR;
          state_d       = ST_DONE;
        end else begin
          state_d = ST_PART;
        end
      end
      ST_PART: begin
        if (sts_i.part_done) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = CLS_UNKNOWN;
          state_d       = ST_DONE;
        end else if (sts_i.part_hit) begin
          if (sts_i.super_hit) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res     = CLS_SUPER;
            state_d       = ST_DONE;
          end else if (sts_i.part_empty) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res     = CLS_PART;
            state_d       = ST_DONE;
          end else begin
            cmd_o.grp_init = 1'b1;
            state_d        = ST_GRP;
          end
        end else begin
          cmd_o.part_next = 1'b1;
        end
      end
      ST_GRP: begin
        if (sts_i.grp_cls != CLS_UNKNOWN) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = sts_i.grp_cls;
          state_d       = ST_DONE;
        end else if (sts_i.grp_last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = CLS_PART;
          state_d       = ST_DONE;
        end else begin
          cmd_o.grp_next = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/disk_write_sector_classifier.sv =====
// Timing: a load item is written into its table as it is accepted. A classify item
//   goes through the MBR check, then as needed the partition scan over the slots in use
//   and the group walk of the hit partition, and waits while the output register is full.
// Throughput: one item at a time; the group walk, one table-memory read per cycle on
//   its single read port, sets the classify rate. Loads go back to back.
// Reset: configuration and group counts clear; table contents hold nothing until loaded.
`timescale 1ns / 1ps
`default_nettype none

module disk_write_sector_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [1:0]  part_index_i,
  input  logic [6:0]  group_index_i,
  input  logic [31:0] sector_i,
  input  logic [31:0] value_a_i,
  input  logic [31:0] value_b_i,
  input  logic [31:0] value_c_i,
  input  logic [31:0] value_d_i,
  input  logic [31:0] value_e_i,
  input  logic [31:0] value_f_i,
  input  logic [2:0]  log_block_size_i,
  input  logic        first_data_block_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  sector_class_o
);
  import dwsc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer: accept items, walk the MBR check, the partition scan and the
  // group walk, then hand the class to the output register when it frees up.
  dwsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: configuration, partition table, group table memory, running
  // data-range bounds and the output register.
  dwsc_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .req_type_i         (req_type_i),
    .part_index_i       (part_index_i),
    .group_index_i      (group_index_i),
    .sector_i           (sector_i),
    .value_a_i          (value_a_i),
    .value_b_i          (value_b_i),
    .value_c_i          (value_c_i),
    .value_d_i          (value_d_i),
    .value_e_i          (value_e_i),
    .value_f_i          (value_f_i),
    .log_block_size_i   (log_block_size_i),
    .first_data_block_i (first_data_block_i),
    .out_ready_i        (out_ready_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .sector_class_o     (sector_class_o)
  );

  // A classify item must make the block busy in the next cycle.
  a_classify_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_CLASSIFY)) |=> !in_ready_o)
    else $error("input still ready after a classify item");

  // A result only appears after the block has been busy.
  a_out_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a busy cycle");

  // Only defined classes leave the block.
  a_class_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sector_class_o <= CLS_PART))
    else $error("undefined sector class");

endmodule

`default_nettype wire
